// ===== rtl/assert_macros.svh =====
// Assertion macros for the kinematics block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/svk_pkg.sv =====
`timescale 1ns / 1ps
package svk_pkg;
	localparam int CordicStepsDef = 16;
	localparam int NumAtan = 24;
	localparam logic signed [33:0] CkGainInv = 34'sd652032874;

	localparam logic [15:0] TickReset  = 16'd3277;
	localparam logic [15:0] MaxReset   = 16'd2560;
	localparam logic [15:0] AccelReset = 16'd512;
	localparam logic [15:0] BrakeReset = 16'd1024;
	localparam logic [15:0] HullReset  = 16'd5461;
	localparam logic [15:0] TurrReset  = 16'd10923;

	typedef enum logic [2:0] {
		REG_TICK  = 3'd0,
		REG_MAX   = 3'd1,
		REG_ACCEL = 3'd2,
		REG_BRAKE = 3'd3,
		REG_HULL  = 3'd4,
		REG_TURR  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLEW,
		ST_CORDIC,
		ST_MULX,
		ST_MULY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic slew;
		logic cordic_init;
		logic cordic_step;
		logic mul_x;
		logic mul_y;
	} cmd_t;

	typedef struct packed {
		logic immob;
		logic cordic_last;
	} status_t;

	function automatic logic [31:0] atan_val(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'd536870912;
				5'd1: r = 32'd316933406;
				5'd2: r = 32'd167458907;
				5'd3: r = 32'd85004756;
				5'd4: r = 32'd42667331;
				5'd5: r = 32'd21354465;
				5'd6: r = 32'd10679838;
				5'd7: r = 32'd5340245;
				5'd8: r = 32'd2670163;
				5'd9: r = 32'd1335087;
				5'd10: r = 32'd667544;
				5'd11: r = 32'd333772;
				5'd12: r = 32'd166886;
				5'd13: r = 32'd83443;
				5'd14: r = 32'd41722;
				5'd15: r = 32'd20861;
				5'd16: r = 32'd10430;
				5'd17: r = 32'd5215;
				5'd18: r = 32'd2608;
				5'd19: r = 32'd1304;
				5'd20: r = 32'd652;
				5'd21: r = 32'd326;
				5'd22: r = 32'd163;
				5'd23: r = 32'd81;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction
endpackage

// ===== rtl/svk_if.sv =====
`timescale 1ns / 1ps
interface svk_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] desired_speed;
	logic signed [15:0] desired_hull;
	logic signed [15:0] desired_turret;
	logic immobilized;
	modport source (output valid, desired_speed, desired_hull, desired_turret, immobilized,
		input ready);
	modport sink (input valid, desired_speed, desired_hull, desired_turret, immobilized,
		output ready);
endinterface

interface svk_out_if;
	logic valid;
	logic ready;
	logic [15:0] speed_now;
	logic signed [15:0] hull_now;
	logic signed [15:0] turret_now;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	modport source (output valid, speed_now, hull_now, turret_now, pos_x, pos_y,
		input ready);
	modport sink (input valid, speed_now, hull_now, turret_now, pos_x, pos_y,
		output ready);
endinterface

// ===== rtl/svk_ctrl.sv =====
`timescale 1ns / 1ps
module svk_ctrl import svk_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t sts,
	output cmd_t    cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SLEW;
			ST_SLEW:   state_d = sts.immob ? ST_DONE : ST_CORDIC;
			ST_CORDIC: if (sts.cordic_last) state_d = ST_MULX;
			ST_MULX:   state_d = ST_MULY;
			ST_MULY:   state_d = ST_DONE;
			ST_DONE:   if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SLEW: begin
				cmd.slew = 1'b1;
				cmd.cordic_init = 1'b1;
			end
			ST_CORDIC: cmd.cordic_step = 1'b1;
			ST_MULX:   cmd.mul_x = 1'b1;
			ST_MULY:   cmd.mul_y = 1'b1;
			ST_DONE:   out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

// ===== rtl/svk_dp.sv =====
`timescale 1ns / 1ps
module svk_dp import svk_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic signed [15:0] desired_speed,
	input  logic [15:0]        desired_hull,
	input  logic [15:0]        desired_turret,
	input  logic               immobilized,
	input  cmd_t               cmd,
	output status_t            sts,
	output logic [15:0]        speed_now,
	output logic [15:0]        hull_now,
	output logic [15:0]        turret_now,
	output logic [31:0]        pos_x,
	output logic [31:0]        pos_y
);
	localparam int Iters = (CORDIC_STEPS < NumAtan) ? CORDIC_STEPS : NumAtan;
	localparam logic [4:0] LastIter = 5'(Iters - 1);

	logic [15:0] tick_q, max_q, accel_q, brake_q, hrate_q, trate_q;
	logic [15:0] speed_q, hull_q, turret_q;
	logic [31:0] x_q, y_q;
	logic [15:0] want_q, thull_q, tturr_q;
	logic immob_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [4:0] it_q;
	logic flip_q;
	logic [31:0] dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= TickReset; max_q <= MaxReset; accel_q <= AccelReset;
			brake_q <= BrakeReset; hrate_q <= HullReset; trate_q <= TurrReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICK:  tick_q <= cfg_data;
				REG_MAX:   max_q <= cfg_data;
				REG_ACCEL: accel_q <= cfg_data;
				REG_BRAKE: brake_q <= cfg_data;
				REG_HULL:  hrate_q <= cfg_data;
				REG_TURR:  trate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp at load
	logic [15:0] want_c;
	always_comb begin
		if (desired_speed[15]) want_c = '0;
		else if ({1'b0, desired_speed[14:0]} > max_q) want_c = max_q;
		else want_c = {1'b0, desired_speed[14:0]};
	end

	// speed slew
	logic [31:0] sprod, hprod, tprod;
	logic [15:0] sstep, speed_n;
	always_comb begin
		sprod = ((want_q >= speed_q) ? accel_q : brake_q) * tick_q;
		sstep = sprod[31:16];
		if (want_q >= speed_q) begin
			speed_n = ((want_q - speed_q) <= sstep) ? want_q : speed_q + sstep;
		end else begin
			speed_n = ((speed_q - want_q) <= sstep) ? want_q : speed_q - sstep;
		end
		hprod = hrate_q * tick_q;
		tprod = trate_q * tick_q;
	end

	function automatic logic [15:0] slew(input logic [15:0] cur, input logic [15:0] tgt,
		input logic [15:0] step);
		logic [15:0] dl;
		logic signed [17:0] d, s;
		begin
			dl = tgt - cur;
			d = (dl > 16'd32768) ? 18'(signed'({2'b0, dl}) - 18'sd65536) : signed'({2'b0, dl});
			s = signed'({2'b0, step});
			if (d > s) d = s;
			if (d < -s) d = -s;
			return cur + d[15:0];
		end
	endfunction

	logic [15:0] hull_n;
	assign hull_n = slew(hull_q, thull_q, hprod[31:16]);

	// cordic start from new hull
	logic [31:0] ang;
	logic fl;
	always_comb begin
		ang = {hull_n, 16'h0};
		fl = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		if (fl) ang = ang + 32'h8000_0000;
	end

	logic signed [33:0] xs, ys, at;
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign at = signed'({2'b0, atan_val(it_q)});

	// distance and multiply
	logic signed [33:0] trig;
	logic signed [66:0] prod;
	logic signed [67:0] rnd;
	logic signed [25:0] disp;
	logic signed [33:0] sum;
	logic [31:0] cur_pos, sat;
	always_comb begin
		trig = cmd.mul_x ? (flip_q ? -cx_q : cx_q) : (flip_q ? -cy_q : cy_q);
		prod = signed'({1'b0, dist_q}) * trig;
		rnd = 68'(prod) + (68'sd1 <<< 41);
		disp = 26'(rnd >>> 42);
		cur_pos = cmd.mul_x ? x_q : y_q;
		sum = 34'(signed'(cur_pos)) + 34'(disp);
		if (sum > 34'sd2147483647) sat = 32'h7FFF_FFFF;
		else if (sum < -34'sd2147483648) sat = 32'h8000_0000;
		else sat = sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0; hull_q <= '0; turret_q <= '0; x_q <= '0; y_q <= '0;
		end else begin
			if (cmd.slew) begin
				if (immob_q) speed_q <= '0;
				else begin
					speed_q <= speed_n;
					hull_q <= hull_n;
					turret_q <= slew(turret_q, tturr_q, tprod[31:16]);
				end
			end
			if (cmd.mul_x) x_q <= sat;
			if (cmd.mul_y) y_q <= sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			want_q <= want_c;
			thull_q <= desired_hull;
			tturr_q <= desired_turret;
			immob_q <= immobilized;
		end
		if (cmd.cordic_init) begin
			cx_q <= CkGainInv;
			cy_q <= '0;
			cz_q <= 34'(signed'(ang));
			it_q <= '0;
			flip_q <= fl;
		end else if (cmd.cordic_step) begin
			if (!cz_q[33]) begin
				cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + at;
			end
			it_q <= it_q + 5'd1;
			// speed already updated, stable through the iterations
			dist_q <= speed_q * tick_q;
		end
	end

	assign sts.immob = immob_q;
	assign sts.cordic_last = (it_q == LastIter);
	assign speed_now = speed_q;
	assign hull_now = hull_q;
	assign turret_now = turret_q;
	assign pos_x = x_q;
	assign pos_y = y_q;
endmodule

// ===== rtl/slew_limited_vehicle_kinematics.sv =====
`timescale 1ns / 1ps
// channel | dir | payload
// in_ch   | in  | desired_speed, desired_hull, desired_turret, immobilized
// out_ch  | out | speed_now, hull_now, turret_now, pos_x, pos_y
// An item goes through load, slew, one CORDIC iteration per cycle, one
// multiply each for x and y, then the result.
// An immobilized item skips the CORDIC and the multiplies. The result holds until taken; no new item
// is taken before that. Reset clears state and restores register defaults.
`include "assert_macros.svh"
module slew_limited_vehicle_kinematics import svk_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDef
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [2:0]  cfg_index,
	input logic [15:0] cfg_data,
	svk_in_if.sink     in_ch,
	svk_out_if.source  out_ch
);
	cmd_t cmd;
	status_t sts;
	logic [15:0] hull_u, turret_u;

	svk_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	svk_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.desired_speed(in_ch.desired_speed),
		.desired_hull(in_ch.desired_hull),
		.desired_turret(in_ch.desired_turret),
		.immobilized(in_ch.immobilized),
		.cmd(cmd), .sts(sts),
		.speed_now(out_ch.speed_now), .hull_now(hull_u), .turret_now(turret_u),
		.pos_x(out_ch.pos_x), .pos_y(out_ch.pos_y)
	);
	assign out_ch.hull_now = signed'(hull_u);
	assign out_ch.turret_now = signed'(turret_u);

	`ASSERT_IMPLIES(a_excl, clk, arst_n, in_ch.ready, !out_ch.valid)
	`ASSERT_NEXT(a_load, clk, arst_n, in_ch.valid && in_ch.ready, cmd.slew)
	`ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, $stable(out_ch.pos_x))
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import svk_pkg::*;

	typedef struct {
		logic [15:0] speed;
		logic [15:0] hull;
		logic [15:0] turret;
		logic [31:0] px;
		logic [31:0] py;
	} kin_state_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	svk_in_if in_ch();
	svk_out_if out_ch();

	slew_limited_vehicle_kinematics u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	localparam int WatchdogLimit = 20000;
	localparam int CordicIters = (CordicStepsDef < NumAtan) ? CordicStepsDef : NumAtan;
	localparam longint GainInv = 64'sd652032874;

	logic [15:0] tick_s, max_spd, accel, brake, hull_rate, turr_rate;
	kin_state_t veh;
	kin_state_t kin_q[$];
	int mismatches;
	int checked;
	int immob_seen;
	int sat_seen;
	int idle_cycles;
	bit timed_out;
	bit stall_en;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [15:0] slew_heading(logic [15:0] cur, logic [15:0] tgt,
		logic [15:0] rate);
		int step;
		int delta;
		logic [15:0] d16;
		step = int'((32'(rate) * 32'(tick_s)) >> 16);
		d16 = tgt - cur;
		delta = int'(d16);
		if (delta > 32768) delta -= 65536;
		if (delta > step) delta = step;
		if (delta < -step) delta = -step;
		return cur + 16'(delta);
	endfunction

	task automatic heading_trig(input logic [15:0] ang, output longint c, output longint s);
		logic [31:0] a;
		longint x, y, z, xs, ys, t;
		bit flip;
		a = {ang, 16'd0};
		flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
		if (flip) a = a + 32'h8000_0000;
		x = GainInv;
		y = 0;
		z = longint'($signed(a));
		for (int i = 0; i < CordicIters; i++) begin
			xs = fshr(x, i);
			ys = fshr(y, i);
			t = longint'(atan_val(5'(i)));
			if (z >= 0) begin
				x -= ys; y += xs; z -= t;
			end else begin
				x += ys; y -= xs; z += t;
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic logic [31:0] advance_coord(logic [31:0] p, longint d, longint trig);
		longint v;
		v = longint'($signed(p)) + fshr(d * trig + (64'sd1 <<< 41), 42);
		if (v > 64'sd2147483647) begin
			v = 64'sd2147483647; sat_seen++;
		end
		if (v < -64'sd2147483648) begin
			v = -64'sd2147483648; sat_seen++;
		end
		return v[31:0];
	endfunction

	task automatic predict_tick(input logic [15:0] ds, input logic [15:0] dh,
		input logic [15:0] dt, input logic imm);
		int want, cur, step, diff, mag;
		longint c, s, d;
		if (imm) begin
			veh.speed = 16'd0;
		end else begin
			want = int'($signed(ds));
			cur = int'(veh.speed);
			if (want < 0) want = 0;
			if (want > int'(max_spd)) want = int'(max_spd);
			step = int'((32'(want >= cur ? accel : brake) * 32'(tick_s)) >> 16);
			diff = want - cur;
			mag = diff < 0 ? -diff : diff;
			if (mag <= step) cur = want;
			else cur += (diff > 0) ? step : -step;
			veh.speed = 16'(cur);
			veh.hull = slew_heading(veh.hull, dh, hull_rate);
			veh.turret = slew_heading(veh.turret, dt, turr_rate);
			heading_trig(veh.hull, c, s);
			d = longint'(veh.speed) * longint'(tick_s);
			veh.px = advance_coord(veh.px, d, c);
			veh.py = advance_coord(veh.py, d, s);
		end
		kin_q.push_back(veh);
	endtask

	task automatic send_tick(input logic [15:0] ds, input logic [15:0] dh,
		input logic [15:0] dt, input logic imm);
		in_ch.valid <= 1'b1;
		in_ch.desired_speed <= ds;
		in_ch.desired_hull <= dh;
		in_ch.desired_turret <= dt;
		in_ch.immobilized <= imm;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_tick(ds, dh, dt, imm);
		if (imm) immob_seen++;
	endtask

	task automatic gap(input int n);
		in_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (kin_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TICK: tick_s = val;
			REG_MAX: max_spd = val;
			REG_ACCEL: accel = val;
			REG_BRAKE: brake = val;
			REG_HULL: hull_rate = val;
			REG_TURR: turr_rate = val;
			default: ;
		endcase
	endtask

	task automatic random_ticks(input int n, input int imm_pct);
		int burst;
		logic [15:0] ds;
		while (n > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && n > 0) begin
				case ($urandom_range(0, 3))
					0: ds = 16'($urandom);
					1: ds = max_spd;
					default: ds = 16'($urandom_range(0, int'(max_spd)));
				endcase
				send_tick(ds, 16'($urandom), 16'($urandom),
					($urandom_range(0, 99) < imm_pct));
				burst--; n--;
			end
			if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 30));
		end
	endtask

	task automatic test_directed();
		send_tick(16'h7FFF, 16'h8000, 16'h8000, 1'b0);
		send_tick(16'h8000, 16'h7FFF, 16'h0000, 1'b0);
		send_tick(16'h0A00, 16'h0000, 16'hFFFF, 1'b0);
		send_tick(16'h0A00, 16'h8000, 16'h8001, 1'b0);
		send_tick(16'h0A00, 16'h4000, 16'hC000, 1'b1);
		send_tick(16'hFFFF, 16'hC000, 16'h4000, 1'b0);
		send_tick(16'h0000, 16'h2000, 16'h2000, 1'b0);
		drain();
	endtask

	task automatic test_extreme_config();
		write_reg(REG_TICK, 16'hFFFF);
		write_reg(REG_MAX, 16'hFFFF);
		write_reg(REG_ACCEL, 16'hFFFF);
		write_reg(REG_BRAKE, 16'hFFFF);
		write_reg(REG_HULL, 16'hFFFF);
		write_reg(REG_TURR, 16'hFFFF);
		write_reg(reg_idx_t'(3'd7), 16'h1234);
		for (int i = 0; i < 6; i++) send_tick(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
		send_tick(16'hFFFF, 16'h4000, 16'h0000, 1'b0);
		send_tick(16'h7FFF, 16'hC000, 16'h8000, 1'b0);
		drain();
		// lower the ceiling below current speed, with slow braking
		write_reg(REG_MAX, 16'h0100);
		write_reg(REG_BRAKE, 16'h0100);
		for (int i = 0; i < 3; i++) send_tick(16'h7FFF, 16'h0000, 16'h0000, 1'b0);
		drain();
		write_reg(REG_TICK, 16'h0000);
		for (int i = 0; i < 3; i++) send_tick(16'h7FFF, 16'h4000, 16'h4000, 1'b0);
		drain();
		write_reg(REG_MAX, 16'h0000);
		write_reg(REG_ACCEL, 16'h0000);
		write_reg(REG_HULL, 16'h0000);
		write_reg(REG_TURR, 16'h0000);
		write_reg(REG_TICK, 16'h8000);
		for (int i = 0; i < 3; i++) send_tick(16'h7FFF, 16'h8000, 16'h8000, 1'b0);
		drain();
	endtask

	task automatic test_saturation();
		write_reg(REG_TICK, 16'hFFFF);
		write_reg(REG_MAX, 16'hFFFF);
		write_reg(REG_ACCEL, 16'hFFFF);
		write_reg(REG_HULL, 16'hFFFF);
		for (int i = 0; i < 40; i++) send_tick(16'h7FFF, 16'h0000, 16'(i), 1'b0);
		for (int i = 0; i < 20; i++) send_tick(16'h7FFF, 16'h8000, 16'(i), 1'b0);
		drain();
	endtask

	task automatic test_random_configs();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_TICK, 16'($urandom));
			write_reg(REG_MAX, 16'($urandom));
			write_reg(REG_ACCEL, 16'($urandom));
			write_reg(REG_BRAKE, 16'($urandom));
			write_reg(REG_HULL, 16'($urandom));
			write_reg(REG_TURR, 16'($urandom));
			random_ticks(200, 8);
			drain();
		end
	endtask

	task automatic test_default_rates();
		write_reg(REG_TICK, TickReset);
		write_reg(REG_MAX, MaxReset);
		write_reg(REG_ACCEL, AccelReset);
		write_reg(REG_BRAKE, BrakeReset);
		write_reg(REG_HULL, HullReset);
		write_reg(REG_TURR, TurrReset);
		random_ticks(250, 5);
		drain();
	endtask

	// result checker
	always @(posedge clk) begin
		kin_state_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			checked++;
			if (kin_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item: speed %0d", out_ch.speed_now);
			end else begin
				e = kin_q.pop_front();
				if (out_ch.speed_now !== e.speed || out_ch.hull_now !== e.hull ||
					out_ch.turret_now !== e.turret || out_ch.pos_x !== e.px ||
					out_ch.pos_y !== e.py) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d exp s=%h h=%h t=%h x=%h y=%h got s=%h h=%h t=%h x=%h y=%h",
							checked, e.speed, e.hull, e.turret, e.px, e.py,
							out_ch.speed_now, out_ch.hull_now, out_ch.turret_now,
							out_ch.pos_x, out_ch.pos_y);
				end
			end
		end
	end

	// receiver stall pattern: long stretches without stalls, then random ones
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_en <= ~stall_en;
		out_ch.ready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
			|| kin_q.size() == 0 && !in_ch.valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit && !timed_out) begin
			timed_out = 1'b1;
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TICK;
		cfg_data = 16'd0;
		in_ch.valid = 1'b0;
		in_ch.desired_speed = 16'd0;
		in_ch.desired_hull = 16'd0;
		in_ch.desired_turret = 16'd0;
		in_ch.immobilized = 1'b0;
		out_ch.ready = 1'b1;
		stall_en = 1'b0;
		mismatches = 0; checked = 0; immob_seen = 0; sat_seen = 0;
		idle_cycles = 0; timed_out = 1'b0;
		tick_s = TickReset; max_spd = MaxReset; accel = AccelReset;
		brake = BrakeReset; hull_rate = HullReset; turr_rate = TurrReset;
		veh = '{default: '0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extreme_config();
		test_saturation();
		test_default_rates();
		test_random_configs();
		drain();
		$display("checked %0d ticks, %0d immobilised, %0d saturated coordinates",
			checked, immob_seen, sat_seen);
		$display("register settings included extremes, zero and random values");
		if (mismatches == 0 && kin_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d left over", mismatches, kin_q.size());
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
